### rtl/core/mlf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlf_pkg: shared types for the motor link failsafe
// Event codes, decoded operation codes and the queue entry between the
// classifier and the executor.
// ----------------------------------------------------------------------------
package mlf_pkg;

   localparam int MODE_W  = 3;
   localparam int MOTOR_W = 16;
   localparam int ID_W    = 16;
   localparam int STEP_W  = 15;
   localparam int N_CH    = 4;

   localparam int CH_FRONT = 0;
   localparam int CH_RIGHT = 1;
   localparam int CH_REAR  = 2;
   localparam int CH_LEFT  = 3;

   localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(10);

   typedef enum logic [MODE_W-1:0] {
      MODE_CMD    = 3'd0,
      MODE_SENSOR = 3'd1,
      MODE_SWITCH = 3'd2,
      MODE_HALT   = 3'd3,
      MODE_TICK   = 3'd4
   } mode_type;

   typedef enum logic [2:0] {
      OP_NOP,
      OP_CMD_LOAD,
      OP_CMD_KEEP,
      OP_SENSOR,
      OP_SWITCH,
      OP_HALT,
      OP_TICK
   } op_type;

   typedef logic signed [MOTOR_W-1:0] motor_type;

   typedef struct packed {
      op_type                     op;
      motor_type [N_CH-1:0]       cmd;
      logic      [ID_W-1:0]       id;
   } entry_type;

endpackage

### rtl/core/mlf_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlf_front: event classifier
// Decodes mode and checksum flags into one operation and hands it, with the
// command payload, to the queue.
// ----------------------------------------------------------------------------
module mlf_front (
   input  logic [mlf_pkg::MODE_W-1:0]  req_mode,
   input  logic                        req_frame_ok,
   input  logic                        req_payload_ok,
   input  mlf_pkg::motor_type          req_cmd_front,
   input  mlf_pkg::motor_type          req_cmd_right,
   input  mlf_pkg::motor_type          req_cmd_rear,
   input  mlf_pkg::motor_type          req_cmd_left,
   input  logic [mlf_pkg::ID_W-1:0]    req_cmd_id,
   output mlf_pkg::entry_type          entry
);
   import mlf_pkg::*;

   op_type op;

   always_comb begin
      op = OP_NOP;
      unique case (req_mode)
         MODE_CMD: begin
            if (req_frame_ok) begin
               op = req_payload_ok ? OP_CMD_LOAD : OP_CMD_KEEP;
            end
         end
         MODE_SENSOR: begin
            if (req_frame_ok) op = OP_SENSOR;
         end
         MODE_SWITCH: begin
            if (req_frame_ok) op = OP_SWITCH;
         end
         MODE_HALT: begin
            if (req_frame_ok) op = OP_HALT;
         end
         MODE_TICK: begin
            // tick acts regardless of checksum
            op = OP_TICK;
         end
         default: begin
            op = OP_NOP;
         end
      endcase
   end

   always_comb begin
      entry.op             = op;
      entry.cmd[CH_FRONT]  = req_cmd_front;
      entry.cmd[CH_RIGHT]  = req_cmd_right;
      entry.cmd[CH_REAR]   = req_cmd_rear;
      entry.cmd[CH_LEFT]   = req_cmd_left;
      entry.id             = req_cmd_id;
   end

endmodule

### rtl/core/mlf_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlf_queue: two-entry queue
// Decouples the classifier from the executor so each side stalls on its own.
// ----------------------------------------------------------------------------
module mlf_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  mlf_pkg::entry_type  push_entry,
   output logic                full,
   input  logic                pop,
   output logic                head_valid,
   output mlf_pkg::entry_type  head_entry
);
   import mlf_pkg::*;

   entry_type  mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full       = (count_ff == 2'd2);
   assign head_valid = (count_ff != 2'd0);
   assign head_entry = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

### rtl/core/mlf_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlf_back: failsafe executor
// Holds the link state and motor values, applies one operation per cycle
// while the result is not stalled and registers the pulses of the result.
// ----------------------------------------------------------------------------
module mlf_back (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_valid,
   input  logic [mlf_pkg::STEP_W-1:0]   csr_data,
   input  logic                         op_valid,
   input  mlf_pkg::entry_type           op_entry,
   output logic                         op_pop,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic                         rsp_pwm_write,
   output mlf_pkg::motor_type [mlf_pkg::N_CH-1:0] motors,
   output logic                         rsp_halted,
   output logic                         rsp_sensors_on,
   output logic                         rsp_link_reset,
   output logic                         rsp_send_report,
   output logic [mlf_pkg::ID_W-1:0]     rsp_report_id,
   output logic                         rsp_sensor_stale
);
   import mlf_pkg::*;

   logic [STEP_W-1:0]     step_ff;
   logic                  halt_ff, halt_in;
   logic                  cmd_seen_ff, cmd_seen_in;
   logic                  sens_seen_ff, sens_seen_in;
   logic                  sens_en_ff, sens_en_in;
   motor_type [N_CH-1:0]  motor_ff, motor_in;
   logic [ID_W-1:0]       id_ff, id_in;
   logic                  valid_ff, valid_in;
   logic                  pwm_ff, pwm_in;
   logic                  lreset_ff, lreset_in;
   logic                  report_ff, report_in;
   logic                  stale_ff, stale_in;

   logic                   airborne;
   motor_type [N_CH-1:0]   descend;
   logic signed [MOTOR_W:0] diff [N_CH];

   assign op_pop = op_valid && (!valid_ff || !rsp_stall);

   // saturating descent on every channel
   always_comb begin
      airborne = 1'b0;
      for (int i = 0; i < N_CH; i++) begin
         if (!motor_ff[i][MOTOR_W-1] && (motor_ff[i] != '0)) airborne = 1'b1;
         diff[i] = {motor_ff[i][MOTOR_W-1], motor_ff[i]} - {2'b00, step_ff};
         if (diff[i][MOTOR_W] && !diff[i][MOTOR_W-1]) begin
            descend[i] = {1'b1, {(MOTOR_W-1){1'b0}}};
         end else begin
            descend[i] = diff[i][MOTOR_W-1:0];
         end
      end
   end

   always_comb begin
      halt_in      = halt_ff;
      cmd_seen_in  = cmd_seen_ff;
      sens_seen_in = sens_seen_ff;
      sens_en_in   = sens_en_ff;
      motor_in     = motor_ff;
      id_in        = id_ff;
      valid_in     = valid_ff && rsp_stall;
      pwm_in       = pwm_ff;
      lreset_in    = lreset_ff;
      report_in    = report_ff;
      stale_in     = stale_ff;
      if (op_pop) begin
         valid_in  = 1'b1;
         pwm_in    = 1'b0;
         lreset_in = 1'b0;
         report_in = 1'b0;
         stale_in  = 1'b0;
         unique case (op_entry.op)
            OP_CMD_LOAD: begin
               cmd_seen_in = 1'b1;
               report_in   = 1'b1;
               motor_in    = op_entry.cmd;
               id_in       = op_entry.id;
               pwm_in      = !halt_ff;
            end
            OP_CMD_KEEP: begin
               cmd_seen_in = 1'b1;
               report_in   = 1'b1;
            end
            OP_SENSOR: begin
               sens_seen_in = 1'b1;
            end
            OP_SWITCH: begin
               halt_in    = 1'b0;
               sens_en_in = 1'b1;
            end
            OP_HALT: begin
               motor_in   = '0;
               pwm_in     = 1'b1;
               halt_in    = 1'b1;
               sens_en_in = 1'b0;
            end
            OP_TICK: begin
               if (!cmd_seen_ff) begin
                  if (!halt_ff) begin
                     motor_in = airborne ? descend : '0;
                     pwm_in   = 1'b1;
                  end
                  lreset_in  = 1'b1;
                  sens_en_in = 1'b0;
               end
               stale_in     = !sens_seen_ff;
               cmd_seen_in  = 1'b0;
               sens_seen_in = 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= STEP_RESET;
         halt_ff      <= 1'b1;
         cmd_seen_ff  <= 1'b0;
         sens_seen_ff <= 1'b0;
         sens_en_ff   <= 1'b0;
         motor_ff     <= '0;
         id_ff        <= '0;
         valid_ff     <= 1'b0;
      end else begin
         if (csr_valid) step_ff <= csr_data;
         halt_ff      <= halt_in;
         cmd_seen_ff  <= cmd_seen_in;
         sens_seen_ff <= sens_seen_in;
         sens_en_ff   <= sens_en_in;
         motor_ff     <= motor_in;
         id_ff        <= id_in;
         valid_ff     <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pwm_ff    <= pwm_in;
      lreset_ff <= lreset_in;
      report_ff <= report_in;
      stale_ff  <= stale_in;
   end

   // state only moves when a new result loads, so levels show the state itself
   assign rsp_valid        = valid_ff;
   assign rsp_pwm_write    = pwm_ff;
   assign motors           = motor_ff;
   assign rsp_halted       = halt_ff;
   assign rsp_sensors_on   = sens_en_ff;
   assign rsp_link_reset   = lreset_ff;
   assign rsp_send_report  = report_ff;
   assign rsp_report_id    = id_ff;
   assign rsp_sensor_stale = stale_ff;

endmodule

### rtl/core/motor_link_failsafe.sv
`timescale 1ns / 1ps
// A result passes through the queue register, then the executor register, after its event transfer.
// Throughput: one event per cycle while rsp_stall is low; the executor applies one operation a cycle.
// A two-entry queue absorbs result stall until it is full; then req_stall rises.
// Reset (synchronous): halted, sensors off, motors and id zero, step 10.
// ----------------------------------------------------------------------------
// motor_link_failsafe: four-channel motor link failsafe
// Classifies link events, queues them and executes them against the
// watchdog, shut-down and motor state.
// ----------------------------------------------------------------------------
module motor_link_failsafe (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [mlf_pkg::MODE_W-1:0]   req_mode,
   input  logic                         req_frame_ok,
   input  logic                         req_payload_ok,
   input  mlf_pkg::motor_type           req_cmd_front,
   input  mlf_pkg::motor_type           req_cmd_right,
   input  mlf_pkg::motor_type           req_cmd_rear,
   input  mlf_pkg::motor_type           req_cmd_left,
   input  logic [mlf_pkg::ID_W-1:0]     req_cmd_id,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic                         rsp_pwm_write,
   output mlf_pkg::motor_type           rsp_out_front,
   output mlf_pkg::motor_type           rsp_out_right,
   output mlf_pkg::motor_type           rsp_out_rear,
   output mlf_pkg::motor_type           rsp_out_left,
   output logic                         rsp_halted,
   output logic                         rsp_sensors_on,
   output logic                         rsp_link_reset,
   output logic                         rsp_send_report,
   output logic [mlf_pkg::ID_W-1:0]     rsp_report_id,
   output logic                         rsp_sensor_stale,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [mlf_pkg::STEP_W-1:0]   csr_data
);
   import mlf_pkg::*;

   entry_type             front_entry;
   entry_type             head_entry;
   logic                  q_full;
   logic                  head_valid;
   logic                  head_pop;
   logic                  push;
   motor_type [N_CH-1:0]  motors;

   assign req_stall = q_full;
   assign push      = req_valid && !q_full;
   assign csr_ready = 1'b1;

   mlf_front u_front (
      .req_mode       (req_mode),
      .req_frame_ok   (req_frame_ok),
      .req_payload_ok (req_payload_ok),
      .req_cmd_front  (req_cmd_front),
      .req_cmd_right  (req_cmd_right),
      .req_cmd_rear   (req_cmd_rear),
      .req_cmd_left   (req_cmd_left),
      .req_cmd_id     (req_cmd_id),
      .entry          (front_entry)
   );

   mlf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (front_entry),
      .full       (q_full),
      .pop        (head_pop),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   mlf_back u_back (
      .clock            (clock),
      .reset            (reset),
      .csr_valid        (csr_valid),
      .csr_data         (csr_data),
      .op_valid         (head_valid),
      .op_entry         (head_entry),
      .op_pop           (head_pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_pwm_write    (rsp_pwm_write),
      .motors           (motors),
      .rsp_halted       (rsp_halted),
      .rsp_sensors_on   (rsp_sensors_on),
      .rsp_link_reset   (rsp_link_reset),
      .rsp_send_report  (rsp_send_report),
      .rsp_report_id    (rsp_report_id),
      .rsp_sensor_stale (rsp_sensor_stale)
   );

   assign rsp_out_front = motors[CH_FRONT];
   assign rsp_out_right = motors[CH_RIGHT];
   assign rsp_out_rear  = motors[CH_REAR];
   assign rsp_out_left  = motors[CH_LEFT];

endmodule

### test/motor_link_failsafe_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// motor_link_failsafe_tb: self-checking regression for the motor link failsafe
// Drives decoded link events through the request channel and checks every
// response against a cycle-free model of the watchdog, shut-down and descend
// logic. The run has four phases with different sender and receiver stall
// mixes, and the descend step is changed between phases while the block is idle.
// ----------------------------------------------------------------------------
module motor_link_failsafe_tb;
   import mlf_pkg::*;

   localparam int RANDOM_PER_PHASE = 280;
   localparam int WATCHDOG_LIMIT   = 2000;
   localparam int LOG_CAP          = 100;

   typedef struct {
      logic [MODE_W-1:0] mode;
      logic              frame_ok;
      logic              payload_ok;
      motor_type         cmd [N_CH];
      logic [ID_W-1:0]   id;
   } link_event_type;

   typedef struct packed {
      logic               pwm_write;
      logic [MOTOR_W-1:0] front;
      logic [MOTOR_W-1:0] right;
      logic [MOTOR_W-1:0] rear;
      logic [MOTOR_W-1:0] left;
      logic               halted;
      logic               sensors_on;
      logic               link_reset;
      logic               send_report;
      logic [ID_W-1:0]    report_id;
      logic               sensor_stale;
   } status_type;

   logic              clock          = 1'b0;
   logic              reset          = 1'b1;
   logic              req_valid      = 1'b0;
   logic              req_stall;
   logic [MODE_W-1:0] req_mode       = '0;
   logic              req_frame_ok   = 1'b0;
   logic              req_payload_ok = 1'b0;
   motor_type         req_cmd_front  = '0;
   motor_type         req_cmd_right  = '0;
   motor_type         req_cmd_rear   = '0;
   motor_type         req_cmd_left   = '0;
   logic [ID_W-1:0]   req_cmd_id     = '0;
   logic              rsp_valid;
   logic              rsp_stall      = 1'b0;
   logic              rsp_pwm_write;
   motor_type         rsp_out_front;
   motor_type         rsp_out_right;
   motor_type         rsp_out_rear;
   motor_type         rsp_out_left;
   logic              rsp_halted;
   logic              rsp_sensors_on;
   logic              rsp_link_reset;
   logic              rsp_send_report;
   logic [ID_W-1:0]   rsp_report_id;
   logic              rsp_sensor_stale;
   logic              csr_valid      = 1'b0;
   logic              csr_ready;
   logic [STEP_W-1:0] csr_data       = '0;

   motor_link_failsafe DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_mode         (req_mode),
      .req_frame_ok     (req_frame_ok),
      .req_payload_ok   (req_payload_ok),
      .req_cmd_front    (req_cmd_front),
      .req_cmd_right    (req_cmd_right),
      .req_cmd_rear     (req_cmd_rear),
      .req_cmd_left     (req_cmd_left),
      .req_cmd_id       (req_cmd_id),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_pwm_write    (rsp_pwm_write),
      .rsp_out_front    (rsp_out_front),
      .rsp_out_right    (rsp_out_right),
      .rsp_out_rear     (rsp_out_rear),
      .rsp_out_left     (rsp_out_left),
      .rsp_halted       (rsp_halted),
      .rsp_sensors_on   (rsp_sensors_on),
      .rsp_link_reset   (rsp_link_reset),
      .rsp_send_report  (rsp_send_report),
      .rsp_report_id    (rsp_report_id),
      .rsp_sensor_stale (rsp_sensor_stale),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_data         (csr_data)
   );

   // model state
   logic              shut_dn   = 1'b1;
   logic              cmd_seen  = 1'b0;
   logic              sens_seen = 1'b0;
   motor_type         motors [N_CH] = '{default: '0};
   logic [ID_W-1:0]   held_id   = '0;
   logic              sens_en   = 1'b0;
   logic [STEP_W-1:0] step_cfg  = STEP_RESET;

   link_event_type pending [$];
   link_event_type in_flight;
   status_type     expected_status [$];

   int send_idle_pct = 0;
   int stall_pct     = 0;
   int err_count     = 0;
   int n_events      = 0;
   int n_results     = 0;
   int n_descend     = 0;
   int n_link_reset  = 0;
   int quiet         = 0;

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic status_type apply_event(input link_event_type ev);
      status_type r;
      logic    airborne;
      int      d;
      int      i;
      r = '0;
      if (ev.mode == MODE_CMD && ev.frame_ok) begin
         cmd_seen = 1'b1;
         if (ev.payload_ok) begin
            for (i = 0; i < N_CH; i++) motors[i] = ev.cmd[i];
            held_id = ev.id;
            r.pwm_write = !shut_dn;
         end
         r.send_report = 1'b1;
      end else if (ev.mode == MODE_SENSOR && ev.frame_ok) begin
         sens_seen = 1'b1;
      end else if (ev.mode == MODE_SWITCH && ev.frame_ok) begin
         shut_dn = 1'b0;
         sens_en = 1'b1;
      end else if (ev.mode == MODE_HALT && ev.frame_ok) begin
         for (i = 0; i < N_CH; i++) motors[i] = '0;
         r.pwm_write = 1'b1;
         shut_dn = 1'b1;
         sens_en = 1'b0;
      end else if (ev.mode == MODE_TICK) begin
         if (!cmd_seen) begin
            if (!shut_dn) begin
               airborne = 1'b0;
               for (i = 0; i < N_CH; i++) if (motors[i] > 0) airborne = 1'b1;
               // descend while any channel is still positive, else cut all
               for (i = 0; i < N_CH; i++) begin
                  if (airborne) begin
                     d = int'(motors[i]) - int'(step_cfg);
                     motors[i] = (d < -32768) ? motor_type'(-32768) : motor_type'(d);
                  end else begin
                     motors[i] = '0;
                  end
               end
               r.pwm_write = 1'b1;
               if (airborne) n_descend++;
            end
            r.link_reset = 1'b1;
            sens_en = 1'b0;
            n_link_reset++;
         end
         r.sensor_stale = !sens_seen;
         cmd_seen = 1'b0;
         sens_seen = 1'b0;
      end
      r.front      = motors[CH_FRONT];
      r.right      = motors[CH_RIGHT];
      r.rear       = motors[CH_REAR];
      r.left       = motors[CH_LEFT];
      r.halted     = shut_dn;
      r.sensors_on = sens_en;
      r.report_id  = held_id;
      return r;
   endfunction

   // request driver: hold the payload while stalled, advance after each transfer
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) step_cfg = csr_data;
         if (req_valid && !req_stall) begin
            expected_status.push_back(apply_event(in_flight));
            n_events++;
         end
         if (!req_valid || !req_stall) begin
            if (pending.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               in_flight = pending.pop_front();
               req_mode       <= in_flight.mode;
               req_frame_ok   <= in_flight.frame_ok;
               req_payload_ok <= in_flight.payload_ok;
               req_cmd_front  <= in_flight.cmd[CH_FRONT];
               req_cmd_right  <= in_flight.cmd[CH_RIGHT];
               req_cmd_rear   <= in_flight.cmd[CH_REAR];
               req_cmd_left   <= in_flight.cmd[CH_LEFT];
               req_cmd_id     <= in_flight.id;
               req_valid      <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   task automatic check_field(input string name, input logic [31:0] want, got);
      if (want !== got) begin
         err_count++;
         // cap the log on a badly broken build
         if (err_count <= LOG_CAP)
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      end
   endtask

   // response monitor
   always @(posedge clock) begin
      status_type got;
      status_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got.pwm_write    = rsp_pwm_write;
            got.front        = rsp_out_front;
            got.right        = rsp_out_right;
            got.rear         = rsp_out_rear;
            got.left         = rsp_out_left;
            got.halted       = rsp_halted;
            got.sensors_on   = rsp_sensors_on;
            got.link_reset   = rsp_link_reset;
            got.send_report  = rsp_send_report;
            got.report_id    = rsp_report_id;
            got.sensor_stale = rsp_sensor_stale;
            n_results++;
            if (expected_status.size() == 0) begin
               err_count++;
               $display("%0t: unexpected response, expected none actual %0h", $time, got);
            end else begin
               want = expected_status.pop_front();
               check_field("pwm_write", 32'(want.pwm_write), 32'(got.pwm_write));
               check_field("out_front", 32'(want.front), 32'(got.front));
               check_field("out_right", 32'(want.right), 32'(got.right));
               check_field("out_rear", 32'(want.rear), 32'(got.rear));
               check_field("out_left", 32'(want.left), 32'(got.left));
               check_field("halted", 32'(want.halted), 32'(got.halted));
               check_field("sensors_on", 32'(want.sensors_on), 32'(got.sensors_on));
               check_field("link_reset", 32'(want.link_reset), 32'(got.link_reset));
               check_field("send_report", 32'(want.send_report), 32'(got.send_report));
               check_field("report_id", 32'(want.report_id), 32'(got.report_id));
               check_field("sensor_stale", 32'(want.sensor_stale), 32'(got.sensor_stale));
            end
         end
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // watchdog on transfers of any channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready)) begin
         quiet <= 0;
      end else if (quiet >= WATCHDOG_LIMIT) begin
         $display("motor_link_failsafe regression: fail");
         $finish;
      end else begin
         quiet <= quiet + 1;
      end
   end

   task automatic push_event(input logic [MODE_W-1:0] mode, input logic fo, input logic pl,
                             input int f, input int r, input int b, input int l,
                             input int id);
      link_event_type ev;
      ev.mode            = mode;
      ev.frame_ok        = fo;
      ev.payload_ok      = pl;
      ev.cmd[CH_FRONT]   = motor_type'(f);
      ev.cmd[CH_RIGHT]   = motor_type'(r);
      ev.cmd[CH_REAR]    = motor_type'(b);
      ev.cmd[CH_LEFT]    = motor_type'(l);
      ev.id              = ID_W'(id);
      pending.push_back(ev);
   endtask

   function automatic int pick_motor();
      case ($urandom_range(7))
         0: return 32767;
         1: return -32768;
         2: return 0;
         3: return $urandom_range(1, 40);
         4: return -int'($urandom_range(1, 40));
         default: return int'(motor_type'($urandom()));
      endcase
   endfunction

   // mostly well-formed traffic, some bad checksums and unused codes
   task automatic push_random(output int counted);
      logic [MODE_W-1:0] mode;
      logic              fo;
      int                sel;
      int                n;
      counted = 0;
      sel = $urandom_range(99);
      if (sel < 8) begin
         // run of ticks to drive the descend sequence
         n = $urandom_range(2, 6);
         repeat (n) push_event(MODE_TICK, 1'($urandom_range(1)), 1'b0, 0, 0, 0, 0, 0);
         counted = n;
         return;
      end
      if (sel < 38)      mode = MODE_CMD;
      else if (sel < 55) mode = MODE_SENSOR;
      else if (sel < 75) mode = MODE_TICK;
      else if (sel < 85) mode = MODE_SWITCH;
      else if (sel < 90) mode = MODE_HALT;
      else if (sel < 95) mode = MODE_W'($urandom_range(int'(MODE_TICK) + 1, (1 << MODE_W) - 1));
      else               mode = MODE_W'($urandom_range(int'(MODE_TICK)));
      fo = ($urandom_range(99) < 88);
      push_event(mode, fo, $urandom_range(99) < 85, pick_motor(), pick_motor(),
                 pick_motor(), pick_motor(), $urandom_range(16'hFFFF));
      counted = 1;
   endtask

   task automatic write_step(input logic [STEP_W-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   task automatic drain();
      while (pending.size() > 0 || req_valid || expected_status.size() > 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   initial begin
      int phase;
      int total;
      int got_n;
      int send_mix [4];
      int stall_mix [4];
      send_mix  = '{0, 63, 0, 15};
      stall_mix = '{0, 0, 63, 15};
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed opening, starting from the shut-down reset state
      push_event(MODE_TICK, 1'b1, 1'b0, 0, 0, 0, 0, 0);
      push_event(MODE_CMD, 1'b0, 1'b1, 100, 200, 300, 400, 16'h5555);
      push_event(MODE_SENSOR, 1'b0, 1'b0, 0, 0, 0, 0, 0);
      push_event(MODE_SWITCH, 1'b0, 1'b0, 0, 0, 0, 0, 0);
      push_event(MODE_HALT, 1'b0, 1'b0, 0, 0, 0, 0, 0);
      push_event(MODE_CMD, 1'b1, 1'b1, 32767, -32768, 0, -1, 16'hFFFF);
      push_event(MODE_SWITCH, 1'b1, 1'b0, 0, 0, 0, 0, 0);
      push_event(MODE_CMD, 1'b1, 1'b0, 1, 2, 3, 4, 16'h1234);
      push_event(MODE_SENSOR, 1'b1, 1'b0, 0, 0, 0, 0, 0);
      push_event(MODE_TICK, 1'b0, 1'b0, 0, 0, 0, 0, 0);
      push_event(MODE_TICK, 1'b1, 1'b1, 0, 0, 0, 0, 0);
      push_event(MODE_SWITCH, 1'b1, 1'b1, 0, 0, 0, 0, 0);
      push_event(MODE_CMD, 1'b1, 1'b1, 5, 0, -3, 20, 16'h8000);
      push_event(MODE_TICK, 1'b1, 1'b0, 0, 0, 0, 0, 0);
      push_event(MODE_TICK, 1'b1, 1'b0, 0, 0, 0, 0, 0);
      push_event(MODE_TICK, 1'b1, 1'b0, 0, 0, 0, 0, 0);
      push_event(MODE_TICK, 1'b1, 1'b0, 0, 0, 0, 0, 0);
      push_event(MODE_W'(int'(MODE_TICK) + 1), 1'b1, 1'b1, 7, 7, 7, 7, 16'h0707);
      push_event(MODE_W'(int'(MODE_TICK) + 2), 1'b0, 1'b1, 0, 0, 0, 0, 0);
      push_event(MODE_W'((1 << MODE_W) - 1), 1'b1, 1'b0, -9, -9, -9, -9, 16'h0909);
      push_event(MODE_CMD, 1'b1, 1'b1, -32768, -32768, -32768, -32768, 0);
      push_event(MODE_TICK, 1'b1, 1'b0, 0, 0, 0, 0, 0);
      push_event(MODE_TICK, 1'b1, 1'b0, 0, 0, 0, 0, 0);
      push_event(MODE_HALT, 1'b1, 1'b0, 0, 0, 0, 0, 0);
      push_event(MODE_TICK, 1'b1, 1'b0, 0, 0, 0, 0, 0);

      for (phase = 0; phase < 4; phase++) begin
         // change the step only with nothing in flight
         case (phase)
            1: write_step('0);
            2: write_step({STEP_W{1'b1}});
            3: write_step(STEP_W'($urandom_range(1, 2000)));
            default: ;
         endcase
         send_idle_pct = send_mix[phase];
         stall_pct     = stall_mix[phase];
         total = 0;
         while (total < RANDOM_PER_PHASE) begin
            push_random(got_n);
            total += got_n;
         end
         drain();
      end
      send_idle_pct = 0;
      stall_pct     = 0;

      if (expected_status.size() != 0) begin
         err_count++;
         $display("%0t: %0d responses never arrived", $time, expected_status.size());
      end
      $display("Checked %0d responses to %0d events under four stall mixes and step sizes",
               n_results, n_events);
      $display("Stale ticks: %0d link resets, %0d of them descending", n_link_reset, n_descend);
      if (err_count == 0) begin
         $display("motor_link_failsafe regression: pass");
      end else begin
         $display("motor_link_failsafe regression: fail");
      end
      $finish;
   end

endmodule
